>>> design/bpc_pkg.sv
`timescale 1ns / 1ps
package bpc_pkg;
   localparam int DIV_W = 32;
   localparam int CSR_W = 48;
   localparam int IDX_W = 3;

   typedef enum logic [IDX_W-1:0] {
      CSR_AC_SIGNED   = 3'd0,
      CSR_AC_UNSIGNED = 3'd1,
      CSR_B_PAIR      = 3'd2,
      CSR_M_PAIR      = 3'd3,
      CSR_OSS         = 3'd4
   } csr_index_type;

   localparam logic signed [31:0] B6_OFFSET  = 32'sd4000;
   localparam logic signed [31:0] B4_OFFSET  = 32'sd32768;
   localparam logic [15:0]        B7_SCALE   = 16'd50000;
   localparam logic signed [31:0] P_COEF_SQ  = 32'sd3038;
   localparam logic signed [31:0] P_COEF_LIN = -32'sd7357;
   localparam logic signed [31:0] P_OFFSET   = 32'sd3791;
   localparam logic signed [31:0] T_MAX      = 32'sd32767;
   localparam logic signed [31:0] T_MIN      = -32'sd32768;
   localparam logic signed [31:0] P_MAX      = 32'sd262143;
endpackage

>>> design/bpc_div.sv
`timescale 1ns / 1ps
module bpc_div
   import bpc_pkg::*;
#(
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [DIV_W-1:0]  divisor,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [DIV_W-1:0]  quotient,
   output logic [SIDE_W-1:0] side_out
);
   logic [DIV_W-1:0]  r_ff [DIV_W];
   logic [DIV_W-1:0]  n_ff [DIV_W];
   logic [DIV_W-1:0]  d_ff [DIV_W];
   logic [SIDE_W-1:0] side_ff [DIV_W];
   logic [DIV_W-1:0]  v_ff;
   logic [DIV_W-1:0]  r_in [DIV_W];
   logic [DIV_W-1:0]  n_in [DIV_W];
   logic [DIV_W-1:0]  r_src [DIV_W];
   logic [DIV_W-1:0]  n_src [DIV_W];
   logic [DIV_W-1:0]  d_src [DIV_W];
   logic [DIV_W:0]    t_w [DIV_W];
   logic [DIV_W:0]    s_w [DIV_W];

   always_comb begin
      for (int k = 0; k < DIV_W; k++) begin
         if (k == 0) begin
            r_src[k] = '0;
            n_src[k] = dividend;
            d_src[k] = divisor;
         end else begin
            r_src[k] = r_ff[k-1];
            n_src[k] = n_ff[k-1];
            d_src[k] = d_ff[k-1];
         end
         t_w[k] = {r_src[k], n_src[k][DIV_W-1]};
         s_w[k] = t_w[k] - {1'b0, d_src[k]};
         if (!s_w[k][DIV_W]) begin
            r_in[k] = s_w[k][DIV_W-1:0];
            n_in[k] = {n_src[k][DIV_W-2:0], 1'b1};
         end else begin
            r_in[k] = t_w[k][DIV_W-1:0];
            n_in[k] = {n_src[k][DIV_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[DIV_W-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < DIV_W; k++) begin
            r_ff[k] <= r_in[k];
            n_ff[k] <= n_in[k];
            d_ff[k] <= d_src[k];
            side_ff[k] <= (k == 0) ? side_in : side_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   assign out_valid = v_ff[DIV_W-1];
   assign quotient  = n_ff[DIV_W-1];
   assign side_out  = side_ff[DIV_W-1];
endmodule

>>> design/barometric_pressure_compensation.sv
`timescale 1ns / 1ps
// Compensates one raw temperature and raw pressure reading per word into true
// temperature in tenths of a degree and true pressure in pascals.
// The request channel carries raw_temperature in req_tdata[15:0] and
// raw_pressure in req_tdata[34:16]. The response carries temperature_tenths
// in rsp_tdata[15:0], pressure_pa in rsp_tdata[33:16], and divide_error in
// rsp_tuser, which marks a word whose results are invalid.
// The user must write calibration words and oversampling on the csr port only
// while idle, not enforced by the block itself; writes take effect at once.
// The datapath is a single pipeline with two 32-stage radix-2 dividers, one
// for the temperature term and one for pressure. A new word may enter
// every cycle while nothing stalls, so throughput is one word per cycle.
// When the receiver holds rsp_tready low with a word pending, the whole
// pipeline freezes and req_tready drops in the same cycle; no word is lost.
// Reset clears the valid bits and the calibration registers to zero.
module barometric_pressure_compensation
   import bpc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [39:0]      req_tdata,  // raw_temperature, raw_pressure
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [39:0]      rsp_tdata,  // temperature_tenths, pressure_pa
   output logic             rsp_tuser,  // divide_error
   input  logic             csr_we,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);
   logic [47:0] ac_s_ff, ac_u_ff;
   logic [31:0] b_ff, m_ff;
   logic [1:0]  oss_ff;

   logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
   logic [15:0]        ac4, ac5, ac6;

   logic adv;
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ac_s_ff <= '0;
         ac_u_ff <= '0;
         b_ff    <= '0;
         m_ff    <= '0;
         oss_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_AC_SIGNED:   ac_s_ff <= csr_wdata[47:0];
            CSR_AC_UNSIGNED: ac_u_ff <= csr_wdata[47:0];
            CSR_B_PAIR:      b_ff    <= csr_wdata[31:0];
            CSR_M_PAIR:      m_ff    <= csr_wdata[31:0];
            CSR_OSS:         oss_ff  <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   assign ac1 = ac_s_ff[47:32];
   assign ac2 = ac_s_ff[31:16];
   assign ac3 = ac_s_ff[15:0];
   assign ac4 = ac_u_ff[47:32];
   assign ac5 = ac_u_ff[31:16];
   assign ac6 = ac_u_ff[15:0];
   assign b1  = b_ff[31:16];
   assign b2  = b_ff[15:0];
   assign mc  = m_ff[31:16];
   assign md  = m_ff[15:0];

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // Temperature front end.
   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic [15:0] ut1_ff;
   logic [18:0] up1_ff, up2_ff, up3_ff, up4_ff;
   logic signed [31:0] prod2_ff, prod2_in;
   logic signed [31:0] x1_3_ff, x1_4_ff, den_w, num_w;
   logic [31:0] num_mag4_ff, den_mag4_ff, num_mag_in, den_mag_in;
   logic        neg4_ff, err4_ff;
   logic signed [16:0] diff_w;
   logic signed [33:0] prod_full;

   always_comb begin
      diff_w    = $signed({1'b0, ut1_ff}) - $signed({1'b0, ac6});
      prod_full = 34'(diff_w * $signed({1'b0, ac5}));
      prod2_in  = prod_full[31:0];
      den_w     = x1_3_ff + 32'(md);
      num_w     = 32'(mc) <<< 11;
      num_mag_in = num_w[31] ? 32'(-num_w) : 32'(num_w);
      den_mag_in = den_w[31] ? 32'(-den_w) : 32'(den_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ut1_ff      <= req_tdata[15:0];
         up1_ff      <= req_tdata[34:16];
         prod2_ff    <= prod2_in;
         up2_ff      <= up1_ff;
         x1_3_ff     <= prod2_ff >>> 15;
         up3_ff      <= up2_ff;
         x1_4_ff     <= x1_3_ff;
         up4_ff      <= up3_ff;
         num_mag4_ff <= num_mag_in;
         den_mag4_ff <= (den_w == 32'sd0) ? 32'd1 : den_mag_in;
         neg4_ff     <= num_w[31] ^ den_w[31];
         err4_ff     <= (den_w == 32'sd0);
      end
   end

   localparam int SIDE1_W = 32 + 19 + 2;
   logic               d1_valid;
   logic [31:0]        d1_q;
   logic [SIDE1_W-1:0] d1_side;

   bpc_div #(.SIDE_W(SIDE1_W)) u_div_t (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v4_ff),
      .dividend  (num_mag4_ff),
      .divisor   (den_mag4_ff),
      .side_in   ({x1_4_ff, up4_ff, neg4_ff, err4_ff}),
      .out_valid (d1_valid),
      .quotient  (d1_q),
      .side_out  (d1_side)
   );

   // Temperature result and pressure coefficients.
   logic signed [31:0] d1_x1, x2_w, b5_w, tt_w;
   logic               d1_neg, d1_err;
   logic [18:0]        d1_up;
   logic signed [15:0] t_sat_w;

   assign d1_x1  = d1_side[SIDE1_W-1 -: 32];
   assign d1_up  = d1_side[20:2];
   assign d1_neg = d1_side[1];
   assign d1_err = d1_side[0];

   always_comb begin
      x2_w = d1_neg ? 32'(-$signed(d1_q)) : $signed(d1_q);
      b5_w = d1_x1 + x2_w;
      tt_w = (b5_w + 32'sd8) >>> 4;
      if (d1_err) begin
         t_sat_w = '0;
      end else if (tt_w > T_MAX) begin
         t_sat_w = 16'sh7fff;
      end else if (tt_w < T_MIN) begin
         t_sat_w = 16'sh8000;
      end else begin
         t_sat_w = tt_w[15:0];
      end
   end

   logic v5_ff, v6_ff, v7_ff, v8_ff, v9_ff, v10_ff, v11_ff;
   logic signed [31:0] b6_5_ff;
   logic signed [15:0] t5_ff, t6_ff, t7_ff, t8_ff, t9_ff, t10_ff, t11_ff;
   logic e5_ff, e6_ff, e7_ff, e8_ff, e9_ff, e10_ff, e11_ff;
   logic [18:0] up5_ff, up6_ff, up7_ff, up8_ff, up9_ff;
   logic signed [31:0] sqp6_ff, pac2_6_ff, pac3_6_ff;
   logic signed [31:0] sq7_ff, x2a7_ff, x1c7_ff, x2a8_ff, x1c8_ff;
   logic signed [31:0] mb2_8_ff, mb1_8_ff;
   logic signed [31:0] b3_9_ff, tb9_ff, b3_w, tb_w, x3_w, s_w, x3b_w;
   logic [31:0] b4_10_ff, diff10_ff, b4_w;
   logic [31:0] b7_11_ff, b4_11_ff;
   logic [47:0] b4_full;
   logic [47:0] b7_full;
   logic signed [63:0] sqp_full, pac2_full, pac3_full, mb2_full, mb1_full;
   logic [15:0] scale_w;

   always_comb begin
      sqp_full  = b6_5_ff * b6_5_ff;
      pac2_full = 64'(b6_5_ff) * 64'(ac2);
      pac3_full = 64'(b6_5_ff) * 64'(ac3);
      mb2_full  = 64'(sq7_ff) * 64'(b2);
      mb1_full  = 64'(sq7_ff) * 64'(b1);
      x3_w      = (mb2_8_ff >>> 11) + x2a8_ff;
      s_w       = (32'(ac1) <<< 2) + x3_w;
      b3_w      = ((s_w <<< oss_ff) + 32'sd2) >>> 2;
      x3b_w     = ((x1c8_ff + (mb1_8_ff >>> 16)) + 32'sd2) >>> 2;
      tb_w      = x3b_w + B4_OFFSET;
      b4_full   = {32'd0, ac4} * {16'd0, tb9_ff};
      b4_w      = {15'd0, b4_full[31:15]};
      scale_w   = B7_SCALE >> oss_ff;
      b7_full   = {16'd0, diff10_ff} * {32'd0, scale_w};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
      end else if (adv) begin
         v5_ff  <= d1_valid;
         v6_ff  <= v5_ff;
         v7_ff  <= v6_ff;
         v8_ff  <= v7_ff;
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
         v11_ff <= v10_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b6_5_ff   <= b5_w - B6_OFFSET;
         t5_ff     <= t_sat_w;
         e5_ff     <= d1_err;
         up5_ff    <= d1_up;
         sqp6_ff   <= sqp_full[31:0];
         pac2_6_ff <= pac2_full[31:0];
         pac3_6_ff <= pac3_full[31:0];
         t6_ff     <= t5_ff;
         e6_ff     <= e5_ff;
         up6_ff    <= up5_ff;
         sq7_ff    <= sqp6_ff >>> 12;
         x2a7_ff   <= pac2_6_ff >>> 11;
         x1c7_ff   <= pac3_6_ff >>> 13;
         t7_ff     <= t6_ff;
         e7_ff     <= e6_ff;
         up7_ff    <= up6_ff;
         mb2_8_ff  <= mb2_full[31:0];
         mb1_8_ff  <= mb1_full[31:0];
         x2a8_ff   <= x2a7_ff;
         x1c8_ff   <= x1c7_ff;
         t8_ff     <= t7_ff;
         e8_ff     <= e7_ff;
         up8_ff    <= up7_ff;
         b3_9_ff   <= b3_w;
         tb9_ff    <= tb_w;
         t9_ff     <= t8_ff;
         e9_ff     <= e8_ff;
         up9_ff    <= up8_ff;
         b4_10_ff  <= b4_w;
         diff10_ff <= {13'd0, up9_ff} - b3_9_ff;
         t10_ff    <= t9_ff;
         e10_ff    <= e9_ff;
         b7_11_ff  <= b7_full[31:0];
         b4_11_ff  <= b4_10_ff;
         t11_ff    <= t10_ff;
         e11_ff    <= e10_ff | (b4_10_ff == 32'd0);
      end
   end

   localparam int SIDE2_W = 16 + 2;
   logic               d2_valid;
   logic [31:0]        d2_q;
   logic [SIDE2_W-1:0] d2_side;

   bpc_div #(.SIDE_W(SIDE2_W)) u_div_p (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v11_ff),
      .dividend  (b7_11_ff[31] ? b7_11_ff : {b7_11_ff[30:0], 1'b0}),
      .divisor   (e11_ff ? 32'd1 : b4_11_ff),
      .side_in   ({t11_ff, e11_ff, b7_11_ff[31]}),
      .out_valid (d2_valid),
      .quotient  (d2_q),
      .side_out  (d2_side)
   );

   // Pressure polynomial correction.
   logic v12_ff, v13_ff, v14_ff;
   logic signed [15:0] t12_ff, t13_ff, t14_ff, rsp_t_ff;
   logic e12_ff, e13_ff, e14_ff, rsp_e_ff;
   logic signed [31:0] p12_ff, p13_ff, p14_ff, x1p12_ff, p_w;
   logic signed [31:0] x1sq13_ff, m2_13_ff, m3_14_ff, x2_14_ff;
   logic signed [31:0] corr_w, pf_w;
   logic signed [63:0] x1sq_full, m2_full, m3_full;
   logic [17:0] rsp_p_ff, p_sat_w;

   always_comb begin
      p_w       = d2_side[0] ? {d2_q[30:0], 1'b0} : d2_q;
      x1sq_full = x1p12_ff * x1p12_ff;
      m2_full   = p12_ff * P_COEF_LIN;
      m3_full   = x1sq13_ff * P_COEF_SQ;
      corr_w    = ((m3_14_ff >>> 16) + x2_14_ff + P_OFFSET) >>> 4;
      pf_w      = p14_ff + corr_w;
      if (e14_ff || pf_w < 32'sd0) begin
         p_sat_w = '0;
      end else if (pf_w > P_MAX) begin
         p_sat_w = '1;
      end else begin
         p_sat_w = pf_w[17:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v12_ff       <= 1'b0;
         v13_ff       <= 1'b0;
         v14_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v12_ff       <= d2_valid;
         v13_ff       <= v12_ff;
         v14_ff       <= v13_ff;
         rsp_valid_ff <= v14_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p12_ff    <= p_w;
         x1p12_ff  <= p_w >>> 8;
         t12_ff    <= d2_side[SIDE2_W-1 -: 16];
         e12_ff    <= d2_side[1];
         x1sq13_ff <= x1sq_full[31:0];
         m2_13_ff  <= m2_full[31:0];
         p13_ff    <= p12_ff;
         t13_ff    <= t12_ff;
         e13_ff    <= e12_ff;
         m3_14_ff  <= m3_full[31:0];
         x2_14_ff  <= m2_13_ff >>> 16;
         p14_ff    <= p13_ff;
         t14_ff    <= t13_ff;
         e14_ff    <= e13_ff;
         rsp_t_ff  <= t14_ff;
         rsp_p_ff  <= p_sat_w;
         rsp_e_ff  <= e14_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_p_ff, rsp_t_ff};
   assign rsp_tuser  = rsp_e_ff;

   a_err_clears_pressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[33:16] == 18'd0)
      else $error("divide error word carries a nonzero pressure");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted while the output word is stalled");

   a_stall_holds_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response word changed");
endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
module testbench
   import bpc_pkg::*;
();

   typedef struct packed {
      logic [15:0] temperature_tenths;
      logic [17:0] pressure_pa;
      logic        divide_error;
   } reading_type;

   class compensation_board;
      logic [47:0] ac_signed, ac_unsigned;
      logic [31:0] b_pair, m_pair;
      logic [1:0]  oss;
      reading_type pending[$];
      int          mismatches;
      int          checked;

      function automatic int asr(int x, int n);
         return x >>> n;
      endfunction

      function automatic int tdiv(int a, int b);
         if (a == 32'sh8000_0000 && b == -1) return a;
         return a / b;
      endfunction

      function automatic reading_type compensate(logic [15:0] ut_raw, logic [18:0] up_raw);
         reading_type r;
         int ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut;
         int x1, x2, x3, den, b5, b6, sq, b3, t, p;
         logic [31:0] b4, b7, pu, up;
         ac1 = $signed(ac_signed[47:32]);
         ac2 = $signed(ac_signed[31:16]);
         ac3 = $signed(ac_signed[15:0]);
         ac4 = int'(ac_unsigned[47:32]);
         ac5 = int'(ac_unsigned[31:16]);
         ac6 = int'(ac_unsigned[15:0]);
         b1 = $signed(b_pair[31:16]);
         b2 = $signed(b_pair[15:0]);
         mc = $signed(m_pair[31:16]);
         md = $signed(m_pair[15:0]);
         ut = int'(ut_raw);
         up = 32'(up_raw);
         r = '0;
         x1 = asr((ut - ac6) * ac5, 15);
         den = x1 + md;
         if (den == 0) begin
            r.divide_error = 1'b1;
            return r;
         end
         x2 = tdiv(mc <<< 11, den);
         b5 = x1 + x2;
         t = asr(b5 + 8, 4);
         if (t > 32767) t = 32767;
         if (t < -32768) t = -32768;
         r.temperature_tenths = t[15:0];
         b6 = b5 - 4000;
         sq = asr(b6 * b6, 12);
         x1 = asr(b2 * sq, 11);
         x2 = asr(ac2 * b6, 11);
         x3 = x1 + x2;
         b3 = asr(((ac1 * 4 + x3) <<< oss) + 2, 2);
         x1 = asr(ac3 * b6, 13);
         x2 = asr(b1 * sq, 16);
         x3 = asr(x1 + x2 + 2, 2);
         b4 = (32'(ac4) * 32'(x3 + 32768)) >> 15;
         if (b4 == 0) begin
            r.divide_error = 1'b1;
            return r;
         end
         b7 = (up - 32'(b3)) * (32'd50000 >> oss);
         pu = (b7 < 32'h8000_0000) ? (b7 << 1) / b4 : (b7 / b4) << 1;
         p = int'(pu);
         x1 = asr(p, 8);
         x1 = x1 * x1;
         x1 = asr(x1 * 3038, 16);
         x2 = asr(-7357 * p, 16);
         p = p + asr(x1 + x2 + 3791, 4);
         if (p < 0) p = 0;
         if (p > 262143) p = 262143;
         r.pressure_pa = p[17:0];
         return r;
      endfunction

      function void note_sample(logic [15:0] ut, logic [18:0] up);
         pending.push_back(compensate(ut, up));
      endfunction

      function void check_reading(reading_type got);
         reading_type want;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected word %h", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Word %0d: expected t=%0d p=%0d e=%0b, got t=%0d p=%0d e=%0b",
                  checked, $signed(want.temperature_tenths), want.pressure_pa,
                  want.divide_error, $signed(got.temperature_tenths), got.pressure_pa,
                  got.divide_error);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tready, rsp_tvalid, rsp_tready = 0, rsp_tuser, csr_we = 0;
   logic [39:0] req_tdata = '0, rsp_tdata;
   logic [IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;
   int send_idle = 0, recv_idle = 0;
   compensation_board board = new();

   always #5 clock = ~clock;

   barometric_pressure_compensation DUT (.*);

   always @(posedge clock) begin
      if (!reset) begin
         rsp_tready <= ($urandom_range(99) >= recv_idle);
         if (rsp_tvalid && rsp_tready)
            board.check_reading({rsp_tdata[15:0], rsp_tdata[33:16], rsp_tuser});
      end
   end

   task automatic write_csr(csr_index_type idx, logic [47:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_AC_SIGNED:   board.ac_signed = value;
         CSR_AC_UNSIGNED: board.ac_unsigned = value;
         CSR_B_PAIR:      board.b_pair = value[31:0];
         CSR_M_PAIR:      board.m_pair = value[31:0];
         default:         board.oss = value[1:0];
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_sample(logic [15:0] ut, logic [18:0] up);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, up, ut};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_sample(ut, up);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic load_calibration(logic [47:0] acs, logic [47:0] acu, logic [31:0] bp,
                                   logic [31:0] mp, logic [1:0] o);
      write_csr(CSR_AC_SIGNED, acs);
      write_csr(CSR_AC_UNSIGNED, acu);
      write_csr(CSR_B_PAIR, bp);
      write_csr(CSR_M_PAIR, mp);
      write_csr(CSR_OSS, {46'b0, o});
   endtask

   task automatic random_phase(int count);
      int kind;
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) begin
            drain();
            kind = $urandom_range(9);
            if (kind < 6)
               load_calibration({16'(408 + $urandom_range(800) - 400),
                                 16'(-72 - $urandom_range(200) + 100),
                                 16'(-14383 + $urandom_range(2000) - 1000)},
                                {16'(32741 + $urandom_range(2000) - 1000),
                                 16'(32757 - $urandom_range(8000)),
                                 16'(23153 + $urandom_range(4000) - 2000)},
                                {16'(6190 + $urandom_range(400) - 200),
                                 16'(4 + $urandom_range(8))},
                                {16'(-8711 + $urandom_range(1000) - 500),
                                 16'(2868 + $urandom_range(600) - 300)},
                                2'($urandom_range(3)));
            else
               load_calibration(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                                $urandom, kind == 9 ? {16'($urandom), 16'h0} : $urandom,
                                2'($urandom_range(3)));
         end
         if ($urandom_range(3) != 0)
            send_sample(16'(27898 + $urandom_range(8000) - 4000),
                        19'(23843 + $urandom_range(20000) - 10000) << board.oss);
         else
            send_sample(16'($urandom), 19'($urandom));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      load_calibration({16'd408, -16'sd72, -16'sd14383}, {16'd32741, 16'd32757, 16'd23153},
                       {16'd6190, 16'd4}, {-16'sd8711, 16'd2868}, 2'd0);
      send_sample(16'd27898, 19'd23843);
      send_sample(16'h0000, 19'h00000);
      send_sample(16'hffff, 19'h7ffff);
      send_sample(16'h8000, 19'h40000);
      drain();
      write_csr(CSR_OSS, 48'd3);
      send_sample(16'd27898, 19'd23843 << 3);
      send_sample(16'hffff, 19'h7ffff);
      drain();
      load_calibration({3{16'h8000}}, {3{16'hffff}}, 32'h8000_8000, 32'h7fff_7fff, 2'd3);
      send_sample(16'h0000, 19'h7ffff);
      send_sample(16'hffff, 19'h00000);
      drain();
      load_calibration({3{16'h7fff}}, {3{16'h0000}}, 32'h7fff_7fff, 32'h8000_0000, 2'd1);
      send_sample(16'h1234, 19'h12345);
      send_sample(16'hffff, 19'h7ffff);
      drain();
      load_calibration(48'h0, {16'h0, 16'h1, 16'h0}, 32'h0, 32'h0001_0000, 2'd2);
      send_sample(16'h0, 19'h1);
      send_sample(16'h5, 19'h100);
      drain();
      load_calibration(48'h0, {16'h0, 16'h1, 16'h0}, 32'h0, 32'h0001_0001, 2'd0);
      send_sample(16'h10, 19'h55555);
      send_sample(16'h2aaa, 19'h2aaaa);
      send_out_phases();
   end

   task automatic send_out_phases;
      send_idle = 10; recv_idle = 67;
      random_phase(250);
      drain();
      send_idle = 67; recv_idle = 10;
      random_phase(250);
      drain();
      send_idle = 0; recv_idle = 0;
      random_phase(250);
      drain();
      $display("Checked %0d result words over directed corner cases and three idling phases.",
               board.checked);
      if (board.mismatches == 0)
         $display("barometric_pressure_compensation: match");
      else
         $display("barometric_pressure_compensation: mismatch");
      $finish;
   endtask

   initial begin
      #20ms;
      $display("barometric_pressure_compensation: mismatch");
      $finish;
   end
endmodule
